FILE: sv/line_segment_densifier_macros.svh
// Assertion macros used by the densifier RTL.
`ifndef LINE_SEGMENT_DENSIFIER_MACROS_SVH
`define LINE_SEGMENT_DENSIFIER_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define LSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define LSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/lsd_pkg.sv
// Shared constants, types and sequencer states of the line segment densifier.
`timescale 1ns / 1ps

package lsd_pkg;

    localparam int MAX_VIA   = 62;
    localparam int FRAC_BITS = 16;

    localparam int COORD_W = 32;
    localparam int STEP_W  = 31;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int MUL_W   = DIFF_W;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ROOT_W  = DIFF_W;
    localparam int REM_W   = ROOT_W + 3;
    localparam int VIA_W   = $clog2(MAX_VIA + 1);
    localparam int CEIL_QW = $clog2(MAX_VIA + 2);
    localparam int CAP_W   = STEP_W + CEIL_QW;
    localparam int CNUM_W  = ROOT_W + 1;
    localparam int NUMP_W  = STEP_W + COORD_W;
    localparam int CNT_W   = $clog2(ROOT_W + 1);

    // 0.1 m rounded to the nearest LSB
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(((1 << FRAC_BITS) + 5) / 10);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIFF,
        S_ABS,
        S_SQX,
        S_SQY,
        S_SUM,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_MULX,
        S_CEIL_GO,
        S_CEIL_WAIT,
        S_DIVX_GO,
        S_DIVX_WAIT,
        S_DIVY_GO,
        S_DIVY_WAIT,
        S_EMIT_FIRST,
        S_EMIT_VIA,
        S_EMIT_LAST
    } t_state;

    // Command to the shift-subtract unit
    typedef struct packed {
        logic               load;
        logic               sqrt;
        logic [REM_W-1:0]   init_rem;
        logic [PROD_W-1:0]  num;
        logic [ROOT_W-1:0]  divisor;
        logic [CNT_W-1:0]   count;
    } t_ds_cmd;

    // Status and result of the shift-subtract unit
    typedef struct packed {
        logic               busy;
        logic [ROOT_W-1:0]  quo;
    } t_ds_rsp;

endpackage

FILE: sv/lsd_divsqrt.sv
// Shared shift-subtract unit: one root bit or one quotient bit per cycle.
`timescale 1ns / 1ps

module lsd_divsqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lsd_pkg::t_ds_cmd  i_cmd,
    output lsd_pkg::t_ds_rsp  o_rsp
);
    import lsd_pkg::*;

    logic [CNT_W-1:0]  r_cnt;
    logic              r_sqrt;
    logic [REM_W-1:0]  r_rem;
    logic [PROD_W-1:0] r_num;
    logic [ROOT_W-1:0] r_quo;
    logic [ROOT_W-1:0] r_div;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic [REM_W:0]    diff;
    logic              ge;

    // Shift in the next digit, then trial-subtract
    always_comb begin
        if (r_sqrt) begin
            rem_sh = {r_rem[REM_W-3:0], r_num[PROD_W-1 -: 2]};
            trial  = {1'b0, r_quo, 2'b01};
        end else begin
            rem_sh = {r_rem[REM_W-2:0], r_num[PROD_W-1]};
            trial  = {{(REM_W-ROOT_W){1'b0}}, r_div};
        end
        diff = {1'b0, rem_sh} - {1'b0, trial};
        ge   = !diff[REM_W];
    end

    // Count remaining steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= i_cmd.count;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Load operands or advance one step
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sqrt <= i_cmd.sqrt;
            r_rem  <= i_cmd.init_rem;
            r_num  <= i_cmd.num;
            r_div  <= i_cmd.divisor;
            r_quo  <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? diff[REM_W-1:0] : rem_sh;
            r_quo <= {r_quo[ROOT_W-2:0], ge};
            r_num <= r_sqrt ? (r_num << 2) : (r_num << 1);
        end
    end

    assign o_rsp.busy = (r_cnt != '0);
    assign o_rsp.quo  = r_quo;

endmodule

FILE: sv/line_segment_densifier.sv
// Line segment densifier: top level with sequencer, shared multiplier and point emitter.
`timescale 1ns / 1ps
// A segment is taken when start is high and busy is low; busy then stays high until the
// end point has been issued. Per segment the block first does its arithmetic, mostly in
// the shared shift-subtract unit (33 steps for the length root, a few for the via count,
// 31 for each step component), and then issues 2 + vias points on consecutive cycles,
// one per cycle, each marked by o_result_strobe for one cycle. The receiver cannot
// stall: every strobed beat must be taken. The end point carries o_last_point, and
// o_clipped is set on every point of a segment whose via count exceeded the limit. The step
// register is written over the cfg channel while busy is low; a step of zero acts as one LSB.

module line_segment_densifier (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [lsd_pkg::COORD_W-1:0] i_start_x,
    input  logic signed [lsd_pkg::COORD_W-1:0] i_start_y,
    input  logic signed [lsd_pkg::COORD_W-1:0] i_end_x,
    input  logic signed [lsd_pkg::COORD_W-1:0] i_end_y,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic        [lsd_pkg::STEP_W-1:0]  i_cfg_data,
    output logic                               o_result_strobe,
    output logic signed [lsd_pkg::COORD_W-1:0] o_point_x,
    output logic signed [lsd_pkg::COORD_W-1:0] o_point_y,
    output logic                               o_last_point,
    output logic                               o_clipped
);
    import lsd_pkg::*;

    t_state r_state, n_state;

    logic [STEP_W-1:0]         r_step_length;
    logic [STEP_W-1:0]         r_step;
    logic [STEP_W-1:0]         r_stepm1;
    logic signed [COORD_W-1:0] r_sx, r_sy, r_ex, r_ey;
    logic signed [DIFF_W-1:0]  r_dx, r_dy;
    logic [MUL_W-1:0]          r_ax, r_ay;
    logic                      r_negx, r_negy;
    logic [CAP_W-1:0]          r_cap;
    logic [PROD_W-1:0]         r_prod;
    logic [PROD_W-1:0]         r_sum;
    logic [ROOT_W-1:0]         r_d;
    logic                      r_clip;
    logic [CNUM_W-1:0]         r_cnum;
    logic [NUMP_W-1:0]         r_numx, r_numy;
    logic [VIA_W-1:0]          r_vias;
    logic [VIA_W-1:0]          r_idx;
    logic signed [COORD_W-1:0] r_stx, r_sty;
    logic signed [COORD_W-1:0] r_px, r_py;

    logic                      r_out_vld;
    logic signed [COORD_W-1:0] r_out_x, r_out_y;
    logic                      r_out_last, r_out_clip;
    logic                      n_out_vld;
    logic signed [COORD_W-1:0] n_out_x, n_out_y;
    logic                      n_out_last;

    logic                      mul_en;
    logic [MUL_W-1:0]          mul_a, mul_b;
    t_ds_cmd                   ds_cmd;
    t_ds_rsp                   ds_rsp;

    logic [CEIL_QW-1:0]        ceil_q;
    logic [COORD_W-1:0]        mag_q;
    logic                      accept;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = !busy;
    assign ceil_q      = ds_rsp.quo[CEIL_QW-1:0];
    assign mag_q       = {{(COORD_W-STEP_W){1'b0}}, ds_rsp.quo[STEP_W-1:0]};

    lsd_divsqrt u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (ds_cmd),
        .o_rsp   (ds_rsp)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:       if (start) n_state = S_DIFF;
            S_DIFF:       n_state = S_ABS;
            S_ABS:        n_state = S_SQX;
            S_SQX:        n_state = S_SQY;
            S_SQY:        n_state = S_SUM;
            S_SUM:        n_state = S_SQRT_GO;
            S_SQRT_GO:    n_state = S_SQRT_WAIT;
            S_SQRT_WAIT:  if (!ds_rsp.busy) n_state = S_MULX;
            S_MULX:       n_state = S_CEIL_GO;
            S_CEIL_GO:    n_state = S_CEIL_WAIT;
            S_CEIL_WAIT:  if (!ds_rsp.busy) n_state = S_DIVX_GO;
            S_DIVX_GO:    n_state = S_DIVX_WAIT;
            S_DIVX_WAIT:  if (!ds_rsp.busy) n_state = S_DIVY_GO;
            S_DIVY_GO:    n_state = S_DIVY_WAIT;
            S_DIVY_WAIT:  if (!ds_rsp.busy) n_state = S_EMIT_FIRST;
            S_EMIT_FIRST: n_state = (r_vias == '0) ? S_EMIT_LAST : S_EMIT_VIA;
            S_EMIT_VIA:   if (r_idx == r_vias) n_state = S_EMIT_LAST;
            S_EMIT_LAST:  n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    // Outputs: multiplier operands, unit commands, result beats
    always_comb begin
        mul_en          = 1'b0;
        mul_a           = '0;
        mul_b           = '0;
        ds_cmd          = '0;
        n_out_vld       = 1'b0;
        n_out_x         = r_px;
        n_out_y         = r_py;
        n_out_last      = 1'b0;
        unique case (r_state)
            S_DIFF: begin
                mul_en = 1'b1;
                mul_a  = {{(MUL_W-STEP_W){1'b0}}, r_step};
                mul_b  = MUL_W'(MAX_VIA + 1);
            end
            S_SQX: begin
                mul_en = 1'b1;
                mul_a  = r_ax;
                mul_b  = r_ax;
            end
            S_SQY: begin
                mul_en = 1'b1;
                mul_a  = r_ay;
                mul_b  = r_ay;
            end
            S_SQRT_GO: begin
                ds_cmd.load  = 1'b1;
                ds_cmd.sqrt  = 1'b1;
                ds_cmd.num   = r_sum;
                ds_cmd.count = CNT_W'(ROOT_W);
            end
            S_MULX: begin
                mul_en = 1'b1;
                mul_a  = {{(MUL_W-STEP_W){1'b0}}, r_step};
                mul_b  = r_ax;
            end
            S_CEIL_GO: begin
                mul_en          = 1'b1;
                mul_a           = {{(MUL_W-STEP_W){1'b0}}, r_step};
                mul_b           = r_ay;
                ds_cmd.load     = 1'b1;
                ds_cmd.init_rem = {{(REM_W-CNUM_W+CEIL_QW){1'b0}},
                                   r_cnum[CNUM_W-1:CEIL_QW]};
                ds_cmd.num      = {r_cnum[CEIL_QW-1:0], {(PROD_W-CEIL_QW){1'b0}}};
                ds_cmd.divisor  = {{(ROOT_W-STEP_W){1'b0}}, r_step};
                ds_cmd.count    = CNT_W'(CEIL_QW);
            end
            S_DIVX_GO: begin
                ds_cmd.load     = 1'b1;
                ds_cmd.init_rem = {{(REM_W-COORD_W){1'b0}}, r_numx[NUMP_W-1:STEP_W]};
                ds_cmd.num      = {r_numx[STEP_W-1:0], {(PROD_W-STEP_W){1'b0}}};
                ds_cmd.divisor  = r_d;
                ds_cmd.count    = CNT_W'(STEP_W);
            end
            S_DIVY_GO: begin
                ds_cmd.load     = 1'b1;
                ds_cmd.init_rem = {{(REM_W-COORD_W){1'b0}}, r_numy[NUMP_W-1:STEP_W]};
                ds_cmd.num      = {r_numy[STEP_W-1:0], {(PROD_W-STEP_W){1'b0}}};
                ds_cmd.divisor  = r_d;
                ds_cmd.count    = CNT_W'(STEP_W);
            end
            S_EMIT_FIRST: begin
                n_out_vld = 1'b1;
                n_out_x   = r_sx;
                n_out_y   = r_sy;
            end
            S_EMIT_VIA: begin
                n_out_vld = 1'b1;
            end
            S_EMIT_LAST: begin
                n_out_vld  = 1'b1;
                n_out_x    = r_ex;
                n_out_y    = r_ey;
                n_out_last = 1'b1;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Control state, step register and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_step_length <= STEP_RESET;
            r_out_vld     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_step_length <= i_cfg_data;
            end
        end
    end

    // Hold the result beat
    always_ff @(posedge i_clk) begin
        r_out_x    <= n_out_x;
        r_out_y    <= n_out_y;
        r_out_last <= n_out_last;
        r_out_clip <= r_clip;
    end

    // Shared multiplier, registered
    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
    end

    // Datapath registers, advanced by the sequencer
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sx   <= i_start_x;
            r_sy   <= i_start_y;
            r_ex   <= i_end_x;
            r_ey   <= i_end_y;
            r_step <= (r_step_length == '0) ? STEP_W'(1) : r_step_length;
        end
        case (r_state)
            S_DIFF: begin
                r_dx <= {r_ex[COORD_W-1], r_ex} - {r_sx[COORD_W-1], r_sx};
                r_dy <= {r_ey[COORD_W-1], r_ey} - {r_sy[COORD_W-1], r_sy};
            end
            S_ABS: begin
                r_negx   <= r_dx[DIFF_W-1];
                r_negy   <= r_dy[DIFF_W-1];
                r_ax     <= r_dx[DIFF_W-1] ? MUL_W'(-r_dx) : MUL_W'(r_dx);
                r_ay     <= r_dy[DIFF_W-1] ? MUL_W'(-r_dy) : MUL_W'(r_dy);
                r_cap    <= r_prod[CAP_W-1:0];
                r_stepm1 <= r_step - 1'b1;
            end
            S_SUM: begin
                r_sum <= r_sum + r_prod;
            end
            S_SQY: begin
                r_sum <= r_prod;
            end
            S_SQRT_WAIT: begin
                r_d <= ds_rsp.quo;
            end
            S_MULX: begin
                r_clip <= ({{(CAP_W-ROOT_W){1'b0}}, r_d} > r_cap);
                r_cnum <= {1'b0, r_d} + {{(CNUM_W-STEP_W){1'b0}}, r_stepm1};
            end
            S_CEIL_GO: begin
                r_numx <= r_prod[NUMP_W-1:0];
            end
            S_CEIL_WAIT: begin
                r_numy <= r_prod[NUMP_W-1:0];
                if (r_clip) begin
                    r_vias <= VIA_W'(MAX_VIA);
                end else if (ceil_q == '0) begin
                    r_vias <= '0;
                end else begin
                    r_vias <= VIA_W'(ceil_q - 1'b1);
                end
            end
            S_DIVX_WAIT: begin
                if (r_d == '0) begin
                    r_stx <= '0;
                end else begin
                    r_stx <= r_negx ? -$signed(mag_q) : $signed(mag_q);
                end
            end
            S_DIVY_WAIT: begin
                if (r_d == '0) begin
                    r_sty <= '0;
                end else begin
                    r_sty <= r_negy ? -$signed(mag_q) : $signed(mag_q);
                end
            end
            S_EMIT_FIRST: begin
                r_px  <= r_sx + r_stx;
                r_py  <= r_sy + r_sty;
                r_idx <= VIA_W'(1);
            end
            S_EMIT_VIA: begin
                r_px  <= r_px + r_stx;
                r_py  <= r_py + r_sty;
                r_idx <= r_idx + 1'b1;
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    assign o_result_strobe = r_out_vld;
    assign o_point_x       = r_out_x;
    assign o_point_y       = r_out_y;
    assign o_last_point    = r_out_last;
    assign o_clipped       = r_out_clip;

`include "line_segment_densifier_macros.svh"

    `LSD_ASSERT_NEXT(a_accept_raises_busy, start && !busy, busy, "busy not raised after accept")
    `LSD_ASSERT_NEXT(a_run_unbroken, o_result_strobe && !o_last_point, o_result_strobe, "gap in a run")
    `LSD_ASSERT_NEXT(a_last_ends_run, o_result_strobe && o_last_point, !o_result_strobe, "beat after end point")
    `LSD_ASSERT_NOW(a_run_opens_at_start, $rose(o_result_strobe), (o_point_x == r_sx) && !o_last_point, "run does not open with the start point")

endmodule

FILE: test/line_segment_densifier_tb.sv
// Self-checking testbench for the line segment densifier: predicts every emitted point.
`timescale 1ns / 1ps

module line_segment_densifier_tb;

    import lsd_pkg::*;

    localparam int QUIET_CYCLES = 4;
    localparam int TAIL_CYCLES  = 150;
    localparam int PRINT_LIMIT  = 100;

    localparam longint unsigned SPAN_MAX  = 64'hFFFF_FFFF;
    localparam longint          COORD_MIN = -64'sd2147483648;
    localparam logic [STEP_W-1:0] STEP_DEFAULT = STEP_W'(((1 << FRAC_BITS) + 5) / 10);

    typedef enum logic [1:0] {
        OP_SEGMENT,
        OP_STEP,
        OP_DRAIN
    } t_op_kind;

    typedef struct {
        t_op_kind                  kind;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
        logic [STEP_W-1:0]         step;
        int                        idle_pct;
    } t_op;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
        logic                      clipped;
    } t_point;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic signed [COORD_W-1:0] i_start_x = '0;
    logic signed [COORD_W-1:0] i_start_y = '0;
    logic signed [COORD_W-1:0] i_end_x = '0;
    logic signed [COORD_W-1:0] i_end_y = '0;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [STEP_W-1:0]         i_cfg_data = '0;
    logic                      o_result_strobe;
    logic signed [COORD_W-1:0] o_point_x;
    logic signed [COORD_W-1:0] o_point_y;
    logic                      o_last_point;
    logic                      o_clipped;

    t_op               work_list[$];
    t_point            due_points[$];
    logic [STEP_W-1:0] step_copy = STEP_DEFAULT;
    int                quiet_count = 0;
    int                mismatch_count = 0;
    int                sender_idle_pct = 9;

    line_segment_densifier DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_end_x         (i_end_x),
        .i_end_y         (i_end_y),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_result_strobe (o_result_strobe),
        .o_point_x       (o_point_x),
        .o_point_y       (o_point_y),
        .o_last_point    (o_last_point),
        .o_clipped       (o_clipped)
    );

    // Free-running clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("line_segment_densifier_tb failed");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        if (mismatch_count < PRINT_LIMIT)
            $display("MISMATCH @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Queue a point at the back of the due list
    task automatic append_due(input t_point p);
        due_points.insert(due_points.size(), p);
    endtask

    // Queue an operation at the back of the work list
    task automatic append_work(input t_op op);
        work_list.insert(work_list.size(), op);
    endtask

    // Floor square root of a 68-bit value
    function automatic logic [33:0] floor_root(input logic [67:0] v);
        logic [33:0] r;
        logic [33:0] c;
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            c = r | (34'd1 << b);
            if (68'(c) * 68'(c) <= v)
                r = c;
        end
        return r;
    endfunction

    // Work out every point a segment yields under the current step
    task automatic trace_segment(input t_op seg);
        longint      sx, sy, ex, ey, dx, dy, stx, sty;
        logic [63:0] ax, ay, stp, d, q, vias;
        logic        clip;
        t_point      p;
        sx = longint'(seg.sx);
        sy = longint'(seg.sy);
        ex = longint'(seg.ex);
        ey = longint'(seg.ey);
        dx = ex - sx;
        dy = ey - sy;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        stp = (step_copy == 0) ? 64'd1 : 64'(step_copy);
        d = 64'(floor_root(68'(ax) * 68'(ax) + 68'(ay) * 68'(ay)));
        q = (d + stp - 64'd1) / stp;
        vias = (q == 0) ? 64'd0 : q - 64'd1;
        clip = 1'b0;
        if (vias > 64'(MAX_VIA)) begin
            vias = 64'(MAX_VIA);
            clip = 1'b1;
        end
        stx = (d == 0) ? 0 : $signed((stp * ax) / d);
        sty = (d == 0) ? 0 : $signed((stp * ay) / d);
        if (dx < 0) stx = -stx;
        if (dy < 0) sty = -sty;
        // start point, vias, end point
        p.x = seg.sx;
        p.y = seg.sy;
        p.last = 1'b0;
        p.clipped = clip;
        append_due(p);
        for (longint i = 1; i <= longint'(vias); i++) begin
            p.x = 32'(sx + i * stx);
            p.y = 32'(sy + i * sty);
            append_due(p);
        end
        p.x = seg.ex;
        p.y = seg.ey;
        p.last = 1'b1;
        append_due(p);
    endtask

    // Driver: present segments and step writes from the work list
    always @(posedge i_clk) begin
        logic go_seg;
        logic go_cfg;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cfg_valid <= 1'b0;
            step_copy = STEP_DEFAULT;
            quiet_count = 0;
        end else begin
            go_seg = start;
            go_cfg = i_cfg_valid;
            if (start && !busy) begin
                trace_segment(work_list.pop_front());
                go_seg = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                step_copy = work_list[0].step;
                void'(work_list.pop_front());
                go_cfg = 1'b0;
            end
            // count cycles with nothing in flight
            if (busy || o_result_strobe || due_points.size() != 0)
                quiet_count = 0;
            else
                quiet_count++;
            if (!go_seg && !go_cfg && work_list.size() != 0) begin
                case (work_list[0].kind)
                    OP_SEGMENT: begin
                        if ($urandom_range(99, 0) >= work_list[0].idle_pct) begin
                            go_seg = 1'b1;
                            i_start_x <= work_list[0].sx;
                            i_start_y <= work_list[0].sy;
                            i_end_x <= work_list[0].ex;
                            i_end_y <= work_list[0].ey;
                        end
                    end
                    OP_STEP: begin
                        if (quiet_count >= QUIET_CYCLES) begin
                            go_cfg = 1'b1;
                            i_cfg_data <= work_list[0].step;
                        end
                    end
                    default: begin
                        if (quiet_count >= QUIET_CYCLES)
                            void'(work_list.pop_front());
                    end
                endcase
            end
            start <= go_seg;
            i_cfg_valid <= go_cfg;
        end
    end

    // Monitor: check every strobed beat against the oldest due point
    always @(posedge i_clk) begin
        t_point want;
        if (i_rst_n && o_result_strobe) begin
            if (due_points.size() == 0) begin
                flag_mismatch($sformatf("unexpected point x=%h y=%h", o_point_x, o_point_y));
            end else begin
                want = due_points.pop_front();
                if (o_point_x !== want.x)
                    flag_mismatch($sformatf("point_x got %h want %h", o_point_x, want.x));
                if (o_point_y !== want.y)
                    flag_mismatch($sformatf("point_y got %h want %h", o_point_y, want.y));
                if (o_last_point !== want.last)
                    flag_mismatch($sformatf("last_point got %b want %b",
                                            o_last_point, want.last));
                if (o_clipped !== want.clipped)
                    flag_mismatch($sformatf("clipped got %b want %b", o_clipped, want.clipped));
            end
        end
    end

    function automatic longint unsigned rand_upto(input longint unsigned n);
        logic [63:0] r;
        r = {$urandom, $urandom};
        return (n == 64'hFFFF_FFFF_FFFF_FFFF) ? r : r % (n + 64'd1);
    endfunction

    task automatic add_segment(input longint sx, input longint sy,
                               input longint ex, input longint ey);
        t_op op;
        op.kind = OP_SEGMENT;
        op.sx = 32'(sx);
        op.sy = 32'(sy);
        op.ex = 32'(ex);
        op.ey = 32'(ey);
        op.step = '0;
        op.idle_pct = sender_idle_pct;
        append_work(op);
    endtask

    task automatic add_step(input logic [STEP_W-1:0] value);
        t_op op;
        op = '{kind: OP_STEP, default: '0};
        op.step = value;
        append_work(op);
    endtask

    task automatic add_drain();
        t_op op;
        op = '{kind: OP_DRAIN, default: '0};
        append_work(op);
    endtask

    // Place a span of the given magnitude anywhere in range, in a random direction
    task automatic place_span(input longint unsigned mag, output longint a, output longint b);
        longint lo;
        lo = COORD_MIN + longint'(rand_upto(SPAN_MAX - mag));
        if ($urandom_range(1, 0)) begin
            a = lo;
            b = lo + longint'(mag);
        end else begin
            a = lo + longint'(mag);
            b = lo;
        end
    endtask

    task automatic add_random_segment(input logic [STEP_W-1:0] step);
        longint unsigned target;
        longint          sx, sy, ex, ey;
        int              pick;
        pick = $urandom_range(99, 0);
        if (pick < 20) begin
            add_segment(longint'($signed($urandom)), longint'($signed($urandom)),
                        longint'($signed($urandom)), longint'($signed($urandom)));
        end else begin
            // mostly lengths a few dozen steps long, some tiny or axis aligned
            if (pick < 30)
                target = 64'($urandom_range(3, 0));
            else
                target = 64'((step == 0) ? 1 : step) * 64'($urandom_range(70, 0));
            if (target > SPAN_MAX)
                target = SPAN_MAX;
            place_span((pick % 7 == 0) ? 64'd0 : rand_upto(target), sx, ex);
            place_span((pick % 5 == 0) ? 64'd0 : rand_upto(target), sy, ey);
            add_segment(sx, sy, ex, ey);
        end
    endtask

    function automatic logic [STEP_W-1:0] random_step();
        case ($urandom_range(3, 0))
            0:       return STEP_W'($urandom_range(100, 1));
            1:       return STEP_W'($urandom_range(65536, 1024));
            2:       return STEP_W'($urandom_range(1 << 24, 1 << 16));
            default: return STEP_W'($urandom);
        endcase
    endfunction

    // Stimulus plan, reset and end of run
    initial begin
        logic [STEP_W-1:0] phase_step;
        longint            s;
        s = longint'(STEP_DEFAULT);
        // directed: default step after reset
        sender_idle_pct = 9;
        add_segment(0, 0, 0, 0);
        add_segment(2147483647, 2147483647, 2147483647, 2147483647);
        add_segment(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        add_segment(COORD_MIN, COORD_MIN, 2147483647, 2147483647);
        add_segment(2147483647, COORD_MIN, COORD_MIN, 2147483647);
        add_segment(0, 0, 3 * s, 0);
        add_segment(0, 0, 63 * s, 0);
        add_segment(0, 0, 63 * s + 1, 0);
        add_segment(100, -100, 100 + s - 1, -100);
        add_segment(0, 0, 0, -5 * s);
        add_segment(1000, 2000, 1000 - 9000, 2000 - 12000);
        add_segment(-1, -1, 0, 0);
        // zero step acts as one LSB
        add_step('0);
        add_segment(0, 0, 5, 0);
        add_segment(0, 0, 70, 3);
        add_segment(7, 7, 7, 7);
        // widest step
        add_step({STEP_W{1'b1}});
        add_segment(COORD_MIN, COORD_MIN, 2147483647, 2147483647);
        add_segment(COORD_MIN, 0, 2147483647, 0);
        add_segment(0, 0, 1, 1);
        // random segments in phases of one step setting each
        phase_step = '0;
        for (int i = 0; i < 360; i++) begin
            if (i == 120)
                sender_idle_pct = 59;
            else if (i == 240)
                sender_idle_pct = 0;
            if (i % 40 == 0) begin
                phase_step = (i == 160) ? 31'd1 : random_step();
                add_step(phase_step);
            end else if (i % 40 == 20) begin
                add_drain();
            end
            add_random_segment(phase_step);
        end
        add_step(STEP_DEFAULT);
        add_segment(0, 0, 10 * s, 10 * s);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (work_list.size() != 0 || due_points.size() != 0 || busy)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("line_segment_densifier_tb passed");
        else
            $display("line_segment_densifier_tb failed");
        $finish;
    end

endmodule

FILE: line_segment_densifier.f
+incdir+sv
sv/lsd_pkg.sv
sv/lsd_divsqrt.sv
sv/line_segment_densifier.sv
test/line_segment_densifier_tb.sv
